// ----- rtl/dgt_pkg.sv -----
// shared constants, types and helpers of the disk grid tessellator
`timescale 1ns / 1ps

package dgt_pkg;

   localparam int STEP_LIMIT    = 256;
   localparam int STEP_W        = 9;
   localparam int ROW_W         = 8;
   localparam int CORDIC_ROUNDS = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int CORDIC_STAGES = (CORDIC_ROUNDS < ATAN_ENTRIES) ? CORDIC_ROUNDS : ATAN_ENTRIES;
   localparam int REDUCE_STEPS  = 4;

   localparam int DIV_N_W     = 26;
   localparam int DIV_Q_W     = 18;
   localparam int DIV_LATENCY = DIV_Q_W + 2;

   localparam int Z_W      = 38;
   localparam int CORDIC_W = 34;
   localparam int POS_W    = 20;
   localparam int COLOR_W  = 16;
   localparam int CFG_W    = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [Z_W-1:0] PI_Q30      = 38'sd3373259426;
   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 38'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

   localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   // corner k offsets, order p0 p1 p2 p0 p2 p3
   localparam logic [5:0] CORNER_DR = 6'b110100;
   localparam logic [5:0] CORNER_DC = 6'b010110;
   localparam logic [2:0] LAST_CORNER = 3'd5;

   localparam logic [16:0] ONE_Q15 = 17'd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_START  = 3'd0,
      CSR_ANGLE_END    = 3'd1,
      CSR_ANGLE_STEPS  = 3'd2,
      CSR_RING_START   = 3'd3,
      CSR_RING_END     = 3'd4,
      CSR_RING_STEPS   = 3'd5,
      CSR_RADIUS_SCALE = 3'd6
   } csr_index_type;

   function automatic logic [STEP_W-1:0] clamp_steps(input logic [STEP_W-1:0] s);
      logic [STEP_W-1:0] r;
      if (s == '0) begin
         r = STEP_W'(1);
      end else if (int'(s) > STEP_LIMIT) begin
         r = STEP_W'(STEP_LIMIT);
      end else begin
         r = s;
      end
      return r;
   endfunction

endpackage

// ----- rtl/dgt_div.sv -----
// pipelined round-to-nearest divider of a signed value by a step count
`timescale 1ns / 1ps

module dgt_div (
   input  logic                               clock,
   input  logic signed [dgt_pkg::DIV_N_W-1:0] numer,
   input  logic        [dgt_pkg::STEP_W-1:0]  steps,
   output logic signed [dgt_pkg::DIV_Q_W:0]   quot
);
   import dgt_pkg::*;

   localparam int A_W = DIV_N_W + 2;
   localparam int D_W = STEP_W + 1;

   typedef struct packed {
      logic [A_W-1:0]     rem;
      logic [D_W-1:0]     den;
      logic [DIV_Q_W-1:0] q;
      logic               neg;
   } div_stage_type;

   div_stage_type stage_ff [DIV_Q_W+1];
   div_stage_type stage_in [DIV_Q_W+1];
   logic signed [A_W-1:0] twice_num;
   logic [A_W-1:0] trial;
   logic signed [DIV_Q_W:0] quot_ff, quot_in;

   always_comb begin
      twice_num = ($signed({{2{numer[DIV_N_W-1]}}, numer}) <<< 1)
                  + $signed({{(A_W-STEP_W){1'b0}}, steps});
      stage_in[0].den = {steps, 1'b0};
      stage_in[0].neg = twice_num[A_W-1];
      stage_in[0].q   = '0;
      // floor of a negative value: magnitude plus divisor minus one
      if (twice_num[A_W-1]) begin
         stage_in[0].rem = A_W'(-twice_num) + {{(A_W-D_W){1'b0}}, stage_in[0].den}
                           - A_W'(1);
      end else begin
         stage_in[0].rem = A_W'(twice_num);
      end
      for (int j = 0; j < DIV_Q_W; j++) begin
         stage_in[j+1] = stage_ff[j];
         trial = {{(A_W-D_W){1'b0}}, stage_ff[j].den} << (DIV_Q_W-1-j);
         if (stage_ff[j].rem >= trial) begin
            stage_in[j+1].rem = stage_ff[j].rem - trial;
            stage_in[j+1].q[DIV_Q_W-1-j] = 1'b1;
         end
      end
      if (stage_ff[DIV_Q_W].neg) begin
         quot_in = -$signed({1'b0, stage_ff[DIV_Q_W].q});
      end else begin
         quot_in = $signed({1'b0, stage_ff[DIV_Q_W].q});
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      quot_ff  <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// ----- rtl/disk_grid_tessellator_top.sv -----
// top level of the disk grid tessellator: sequencer, lerp, cordic and color pipeline
// throughput: one vertex per cycle while a cell is active, set by the vertex sequencer
// the pipeline carries a new vertex every cycle and the result channel cannot stall
// synchronous reset clears the sequencer, valid bits and configuration registers to their defaults
`timescale 1ns / 1ps

module disk_grid_tessellator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dgt_pkg::ROW_W-1:0]           req_cell_row,
   input  logic [dgt_pkg::ROW_W-1:0]           req_cell_col,
   input  logic                                csr_write_en,
   input  logic [dgt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dgt_pkg::CFG_W-1:0]           csr_wdata,
   output logic                                rsp_valid,
   output logic signed [dgt_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [dgt_pkg::POS_W-1:0]    rsp_pos_z,
   output logic [dgt_pkg::COLOR_W-1:0]         rsp_color_red,
   output logic [dgt_pkg::COLOR_W-1:0]         rsp_color_green,
   output logic [dgt_pkg::COLOR_W-1:0]         rsp_color_blue,
   output logic [dgt_pkg::COLOR_W-1:0]         rsp_tex_u,
   output logic [dgt_pkg::COLOR_W-1:0]         rsp_tex_v,
   output logic                                rsp_last_vertex
);
   import dgt_pkg::*;

   localparam int SIDE_DEPTH = REDUCE_STEPS + CORDIC_STAGES + 2;

   typedef struct packed {
      logic                      vld;
      logic                      last;
      logic signed [POS_W-1:0]   srad;
      logic [COLOR_W-1:0]        u;
      logic [COLOR_W-1:0]        v;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        blue;
   } side_type;

   typedef struct packed {
      logic signed [Z_W-1:0] w;
      logic                  flip;
      logic                  neg;
   } red_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      logic                       flip;
   } cord_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [22:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 23'sd524287) begin
         r = 20'sh7FFFF;
      end else if (v < -23'sd524288) begin
         r = 20'sh80000;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   // configuration registers
   logic [CFG_W-1:0]  angle_start_ff, angle_end_ff, ring_start_ff, ring_end_ff;
   logic [CFG_W-1:0]  radius_scale_ff;
   logic [STEP_W-1:0] angle_steps_ff, ring_steps_ff;
   logic [STEP_W-1:0] nu, nv, nu_m1, nv_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_start_ff  <= 16'd0;
         angle_end_ff    <= 16'd25736;
         angle_steps_ff  <= 9'd32;
         ring_start_ff   <= 16'd2048;
         ring_end_ff     <= 16'd4096;
         ring_steps_ff   <= 9'd1;
         radius_scale_ff <= 16'd4096;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ANGLE_START:  angle_start_ff  <= csr_wdata;
            CSR_ANGLE_END:    angle_end_ff    <= csr_wdata;
            CSR_ANGLE_STEPS:  angle_steps_ff  <= csr_wdata[STEP_W-1:0];
            CSR_RING_START:   ring_start_ff   <= csr_wdata;
            CSR_RING_END:     ring_end_ff     <= csr_wdata;
            CSR_RING_STEPS:   ring_steps_ff   <= csr_wdata[STEP_W-1:0];
            CSR_RADIUS_SCALE: radius_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nu    = clamp_steps(angle_steps_ff);
   assign nv    = clamp_steps(ring_steps_ff);
   assign nu_m1 = nu - STEP_W'(1);
   assign nv_m1 = nv - STEP_W'(1);

   // vertex sequencer
   logic             active_ff;
   logic [2:0]       k_ff;
   logic [ROW_W-1:0] row_ff, col_ff, row_in, col_in;
   logic             accept;

   assign busy   = active_ff && (k_ff != LAST_CORNER);
   assign accept = start && !busy;
   assign row_in = ({1'b0, req_cell_row} > nv_m1) ? nv_m1[ROW_W-1:0] : req_cell_row;
   assign col_in = ({1'b0, req_cell_col} > nu_m1) ? nu_m1[ROW_W-1:0] : req_cell_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         k_ff      <= '0;
      end else if (accept) begin
         active_ff <= 1'b1;
         k_ff      <= '0;
      end else if (active_ff) begin
         if (k_ff == LAST_CORNER) begin
            active_ff <= 1'b0;
         end else begin
            k_ff <= k_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // corner point and lerp numerators
   logic [STEP_W-1:0]         grid_r, grid_c;
   logic signed [16:0]        ang_diff, rad_diff;
   logic signed [26:0]        ang_prod, rad_prod;
   logic                      p1_vld_ff, p1_last_ff;
   logic signed [DIV_N_W-1:0] n_u_ff, n_v_ff, n_rad_ff, n_ang_ff;

   always_comb begin
      grid_r   = {1'b0, row_ff} + {{(STEP_W-1){1'b0}}, CORNER_DR[k_ff]};
      grid_c   = {1'b0, col_ff} + {{(STEP_W-1){1'b0}}, CORNER_DC[k_ff]};
      ang_diff = $signed({angle_end_ff[CFG_W-1], angle_end_ff})
                 - $signed({angle_start_ff[CFG_W-1], angle_start_ff});
      rad_diff = $signed({ring_end_ff[CFG_W-1], ring_end_ff})
                 - $signed({ring_start_ff[CFG_W-1], ring_start_ff});
      ang_prod = ang_diff * $signed({1'b0, grid_c});
      rad_prod = rad_diff * $signed({1'b0, grid_r});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= active_ff;
      end
      p1_last_ff <= (k_ff == LAST_CORNER);
      n_u_ff     <= $signed({2'b00, grid_c, 15'd0});
      n_v_ff     <= $signed({2'b00, grid_r, 15'd0});
      n_ang_ff   <= ang_prod[DIV_N_W-1:0];
      n_rad_ff   <= rad_prod[DIV_N_W-1:0];
   end

   logic signed [DIV_Q_W:0] q_u, q_v, q_rad, q_ang;

   dgt_div u_div_u   (.clock(clock), .numer(n_u_ff),   .steps(nu), .quot(q_u));
   dgt_div u_div_v   (.clock(clock), .numer(n_v_ff),   .steps(nv), .quot(q_v));
   dgt_div u_div_rad (.clock(clock), .numer(n_rad_ff), .steps(nv), .quot(q_rad));
   dgt_div u_div_ang (.clock(clock), .numer(n_ang_ff), .steps(nu), .quot(q_ang));

   logic d_vld_ff [DIV_LATENCY];
   logic d_last_ff [DIV_LATENCY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LATENCY; i++) begin
            d_vld_ff[i] <= 1'b0;
         end
      end else begin
         d_vld_ff[0] <= p1_vld_ff;
         for (int i = 1; i < DIV_LATENCY; i++) begin
            d_vld_ff[i] <= d_vld_ff[i-1];
         end
      end
      d_last_ff[0] <= p1_last_ff;
      for (int i = 1; i < DIV_LATENCY; i++) begin
         d_last_ff[i] <= d_last_ff[i-1];
      end
   end

   // angle, radius and color products
   logic signed [19:0]          ang_sum, rad_sum;
   logic                        a_vld_ff, a_last_ff;
   logic signed [Z_W-1:0]       a_z_ff;
   logic signed [36:0]          a_sprod_ff;
   logic [COLOR_W-1:0]          a_u_ff, a_v_ff;
   logic [31:0]                 a_uv_ff, a_bp_ff;
   logic [33:0]                 bp_prod;
   logic [COLOR_W-1:0]          u_val, v_val;

   always_comb begin
      ang_sum = $signed({{4{angle_start_ff[CFG_W-1]}}, angle_start_ff})
                + $signed({q_ang[DIV_Q_W], q_ang});
      rad_sum = $signed({{4{ring_start_ff[CFG_W-1]}}, ring_start_ff})
                + $signed({q_rad[DIV_Q_W], q_rad});
      u_val   = q_u[COLOR_W-1:0];
      v_val   = q_v[COLOR_W-1:0];
      bp_prod = (ONE_Q15 - {1'b0, v_val}) * (ONE_Q15 - {1'b0, u_val});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= d_vld_ff[DIV_LATENCY-1];
      end
      a_last_ff  <= d_last_ff[DIV_LATENCY-1];
      a_z_ff     <= $signed({ang_sum, 18'd0});
      a_sprod_ff <= rad_sum * $signed({1'b0, radius_scale_ff});
      a_u_ff     <= u_val;
      a_v_ff     <= v_val;
      a_uv_ff    <= u_val * v_val;
      a_bp_ff    <= bp_prod[31:0];
   end

   // side data, angle reduction and cordic
   side_type side_ff [SIDE_DEPTH];
   side_type side_in0;
   red_type  red_ff [REDUCE_STEPS+1];
   red_type  red_in [REDUCE_STEPS+1];
   cord_type cord_ff [CORDIC_STAGES+1];
   cord_type cord_in [CORDIC_STAGES+1];
   logic [36:0] srad_full;
   logic [31:0] uv_rnd, bp_rnd;
   logic [16:0] green_full;
   logic signed [Z_W-1:0] z_red;
   logic signed [CORDIC_W-1:0] atan_step;

   always_comb begin
      srad_full      = a_sprod_ff + 37'sd2048;
      uv_rnd         = a_uv_ff + 32'd16384;
      bp_rnd         = a_bp_ff + 32'd16384;
      green_full     = ONE_Q15 - {1'b0, a_v_ff} + uv_rnd[31:15];
      side_in0.vld   = a_vld_ff;
      side_in0.last  = a_last_ff;
      side_in0.srad  = $signed(srad_full[31:12]);
      side_in0.u     = a_u_ff;
      side_in0.v     = a_v_ff;
      side_in0.green = green_full[COLOR_W-1:0];
      side_in0.blue  = bp_rnd[30:15];

      red_in[0].neg  = a_z_ff[Z_W-1];
      red_in[0].flip = 1'b0;
      red_in[0].w    = a_z_ff[Z_W-1] ? -a_z_ff : a_z_ff;
      for (int j = 0; j < REDUCE_STEPS; j++) begin
         red_in[j+1] = red_ff[j];
         if ($signed(red_ff[j].w) > HALF_PI_Q30) begin
            red_in[j+1].w    = $signed(red_ff[j].w) - PI_Q30;
            red_in[j+1].flip = !red_ff[j].flip;
         end
      end

      z_red = red_ff[REDUCE_STEPS].neg ? -$signed(red_ff[REDUCE_STEPS].w)
                                       : $signed(red_ff[REDUCE_STEPS].w);
      cord_in[0].x    = GAIN_Q30;
      cord_in[0].y    = '0;
      cord_in[0].z    = z_red[CORDIC_W-1:0];
      cord_in[0].flip = red_ff[REDUCE_STEPS].flip;
      atan_step       = '0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         atan_step          = $signed({2'b00, ATAN_TABLE[i]});
         cord_in[i+1].flip  = cord_ff[i].flip;
         if ($signed(cord_ff[i].z) >= 0) begin
            cord_in[i+1].x = $signed(cord_ff[i].x) - ($signed(cord_ff[i].y) >>> i);
            cord_in[i+1].y = $signed(cord_ff[i].y) + ($signed(cord_ff[i].x) >>> i);
            cord_in[i+1].z = $signed(cord_ff[i].z) - atan_step;
         end else begin
            cord_in[i+1].x = $signed(cord_ff[i].x) + ($signed(cord_ff[i].y) >>> i);
            cord_in[i+1].y = $signed(cord_ff[i].y) - ($signed(cord_ff[i].x) >>> i);
            cord_in[i+1].z = $signed(cord_ff[i].z) + atan_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SIDE_DEPTH; s++) begin
            side_ff[s].vld <= 1'b0;
         end
      end else begin
         side_ff[0] <= side_in0;
         for (int s = 1; s < SIDE_DEPTH; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
      red_ff[0] <= red_in[0];
      for (int j = 1; j <= REDUCE_STEPS; j++) begin
         red_ff[j] <= red_in[j];
      end
      cord_ff[0] <= cord_in[0];
      for (int i = 1; i <= CORDIC_STAGES; i++) begin
         cord_ff[i] <= cord_in[i];
      end
   end

   // position products and output register
   logic signed [CORDIC_W-1:0] cs_full, sn_full;
   logic signed [31:0]         cs32, sn32;
   side_type                   m_side_ff;
   logic signed [51:0]         m_px_ff, m_pz_ff;
   logic signed [52:0]         px_rnd, pz_rnd;

   always_comb begin
      cs_full = cord_ff[CORDIC_STAGES].flip ? -$signed(cord_ff[CORDIC_STAGES].x)
                                            : $signed(cord_ff[CORDIC_STAGES].x);
      sn_full = cord_ff[CORDIC_STAGES].flip ? -$signed(cord_ff[CORDIC_STAGES].y)
                                            : $signed(cord_ff[CORDIC_STAGES].y);
      cs32    = cs_full[31:0];
      sn32    = sn_full[31:0];
      px_rnd  = $signed({m_px_ff[51], m_px_ff}) + 53'sd536870912;
      pz_rnd  = -$signed({m_pz_ff[51], m_pz_ff}) + 53'sd536870912;
   end

   logic                      out_vld_ff, out_last_ff;
   logic signed [POS_W-1:0]   out_px_ff, out_pz_ff;
   logic [COLOR_W-1:0]        out_red_ff, out_green_ff, out_blue_ff, out_u_ff, out_v_ff;

   always_ff @(posedge clock) begin
      m_px_ff   <= $signed(side_ff[SIDE_DEPTH-1].srad) * cs32;
      m_pz_ff   <= $signed(side_ff[SIDE_DEPTH-1].srad) * sn32;
      if (reset) begin
         m_side_ff.vld <= 1'b0;
         out_vld_ff    <= 1'b0;
         out_last_ff   <= 1'b0;
      end else begin
         m_side_ff   <= side_ff[SIDE_DEPTH-1];
         out_vld_ff  <= m_side_ff.vld;
         out_last_ff <= m_side_ff.vld && m_side_ff.last;
      end
      out_px_ff    <= sat_pos(px_rnd[52:30]);
      out_pz_ff    <= sat_pos(pz_rnd[52:30]);
      out_red_ff   <= m_side_ff.v;
      out_green_ff <= m_side_ff.green;
      out_blue_ff  <= m_side_ff.blue;
      out_u_ff     <= m_side_ff.u;
      out_v_ff     <= m_side_ff.v;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_last_vertex = out_last_ff;
   assign rsp_pos_x       = out_px_ff;
   assign rsp_pos_z       = out_pz_ff;
   assign rsp_color_red   = out_red_ff;
   assign rsp_color_green = out_green_ff;
   assign rsp_color_blue  = out_blue_ff;
   assign rsp_tex_u       = out_u_ff;
   assign rsp_tex_v       = out_v_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("sequencer not busy after taking an item");

   a_last_run: assert property (@(posedge clock) disable iff (reset)
      rsp_last_vertex |-> rsp_valid && $past(rsp_valid, 5))
      else $error("last vertex without a full run of six");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_vertex |=> rsp_valid)
      else $error("gap inside a vertex run");
`endif

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench of the tessellator: directed and random cells and settings, scoreboard
`timescale 1ns / 1ps

module tb_top;
   import dgt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_z;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] tex_u;
      logic [COLOR_W-1:0] tex_v;
      logic               last;
   } vertex_type;

   class tessellation_scoreboard;
      vertex_type vertex_queue[$];
      int      error_count;
      logic [15:0] regs[8];

      function new();
         error_count = 0;
         regs[CSR_ANGLE_START]  = 16'd0;
         regs[CSR_ANGLE_END]    = 16'd25736;
         regs[CSR_ANGLE_STEPS]  = 16'd32;
         regs[CSR_RING_START]   = 16'd2048;
         regs[CSR_RING_END]     = 16'd4096;
         regs[CSR_RING_STEPS]   = 16'd1;
         regs[CSR_RADIUS_SCALE] = 16'd4096;
      endfunction

      function void write_reg(int idx, logic [15:0] val);
         if (idx == CSR_ANGLE_STEPS || idx == CSR_RING_STEPS) begin
            regs[idx] = {7'd0, val[8:0]};
         end else if (idx <= CSR_RADIUS_SCALE) begin
            regs[idx] = val;
         end
      endfunction

      function longint floor_div(longint num, longint den);
         if (num >= 0) return num / den;
         return -((-num + den - 1) / den);
      endfunction

      function longint round_div(longint num, longint den);
         return floor_div(2 * num + den, 2 * den);
      endfunction

      function longint steps_of(logic [15:0] s);
         if (s[8:0] == 0) return 1;
         if (s[8:0] > STEP_LIMIT) return STEP_LIMIT;
         return longint'(s[8:0]);
      endfunction

      function longint saturate(longint v);
         if (v > 524287) return 524287;
         if (v < -524288) return -524288;
         return v;
      endfunction

      function void rotate(longint ang, output longint cs, output longint sn);
         longint z, x, y, nx;
         bit flip;
         z = ang * 262144;
         x = GAIN_Q30;
         y = 0;
         flip = 0;
         while (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = !flip;
         end
         while (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            flip = !flip;
         end
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= longint'(ATAN_TABLE[i]);
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += longint'(ATAN_TABLE[i]);
            end
            x = nx;
         end
         cs = flip ? -x : x;
         sn = flip ? -y : y;
      endfunction

      function void note_cell(logic [7:0] row_in, logic [7:0] col_in);
         longint nu, nv, row, col, a0, a1, r0, r1, scale;
         longint r, c, u, v, rad, srad, ang, cs, sn;
         vertex_type vx;
         nu = steps_of(regs[CSR_ANGLE_STEPS]);
         nv = steps_of(regs[CSR_RING_STEPS]);
         row = row_in;
         col = col_in;
         a0 = longint'($signed(regs[CSR_ANGLE_START]));
         a1 = longint'($signed(regs[CSR_ANGLE_END]));
         r0 = longint'($signed(regs[CSR_RING_START]));
         r1 = longint'($signed(regs[CSR_RING_END]));
         scale = longint'(regs[CSR_RADIUS_SCALE]);
         if (row > nv - 1) row = nv - 1;
         if (col > nu - 1) col = nu - 1;
         for (int k = 0; k < 6; k++) begin
            r = row + CORNER_DR[k];
            c = col + CORNER_DC[k];
            u = round_div(c * 32768, nu);
            v = round_div(r * 32768, nv);
            rad = r0 + round_div((r1 - r0) * r, nv);
            srad = floor_div(rad * scale + 2048, 4096);
            ang = a0 + round_div((a1 - a0) * c, nu);
            rotate(ang, cs, sn);
            vx.pos_x = POS_W'(saturate(floor_div(srad * cs + (64'sd1 << 29), 64'sd1 << 30)));
            vx.pos_z = POS_W'(saturate(floor_div(-(srad * sn) + (64'sd1 << 29), 64'sd1 << 30)));
            vx.red   = COLOR_W'(v);
            vx.green = COLOR_W'(32768 - v + ((u * v + 16384) >> 15));
            vx.blue  = COLOR_W'(((32768 - v) * (32768 - u) + 16384) >> 15);
            vx.tex_u = COLOR_W'(u);
            vx.tex_v = COLOR_W'(v);
            vx.last  = (k == LAST_CORNER);
            vertex_queue.insert(vertex_queue.size(), vx);
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         error_count++;
      endtask

      task check_vertex(vertex_type got);
         vertex_type want;
         if (vertex_queue.size() == 0) begin
            report("vertex with no item pending");
            return;
         end
         want = vertex_queue.pop_front();
         if (got.pos_x !== want.pos_x)
            report($sformatf("pos_x got %h want %h", got.pos_x, want.pos_x));
         if (got.pos_z !== want.pos_z)
            report($sformatf("pos_z got %h want %h", got.pos_z, want.pos_z));
         if (got.red !== want.red)
            report($sformatf("red got %h want %h", got.red, want.red));
         if (got.green !== want.green)
            report($sformatf("green got %h want %h", got.green, want.green));
         if (got.blue !== want.blue)
            report($sformatf("blue got %h want %h", got.blue, want.blue));
         if (got.tex_u !== want.tex_u)
            report($sformatf("tex_u got %h want %h", got.tex_u, want.tex_u));
         if (got.tex_v !== want.tex_v)
            report($sformatf("tex_v got %h want %h", got.tex_v, want.tex_v));
         if (got.last !== want.last)
            report($sformatf("last got %b want %b", got.last, want.last));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [ROW_W-1:0]     req_cell_row;
   logic [ROW_W-1:0]     req_cell_col;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   logic                 rsp_valid;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_z;
   logic [COLOR_W-1:0]   rsp_color_red;
   logic [COLOR_W-1:0]   rsp_color_green;
   logic [COLOR_W-1:0]   rsp_color_blue;
   logic [COLOR_W-1:0]   rsp_tex_u;
   logic [COLOR_W-1:0]   rsp_tex_v;
   logic                 rsp_last_vertex;

   tessellation_scoreboard sb = new();
   int idle_pct;
   int cycle_count = 0;

   disk_grid_tessellator_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL disk_grid_tessellator_top");
         $finish;
      end
   end

   always @(posedge clock) begin
      vertex_type got;
      if (!reset && rsp_valid) begin
         got.pos_x = rsp_pos_x;
         got.pos_z = rsp_pos_z;
         got.red   = rsp_color_red;
         got.green = rsp_color_green;
         got.blue  = rsp_color_blue;
         got.tex_u = rsp_tex_u;
         got.tex_v = rsp_tex_v;
         got.last  = rsp_last_vertex;
         sb.check_vertex(got);
      end
   end

   task write_reg(int idx, logic [15:0] val);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = CSR_IDX_W'(idx);
      csr_wdata = val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task wait_drained();
      while (sb.vertex_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task send_cell(logic [7:0] row, logic [7:0] col);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_cell_row = row;
      req_cell_col = col;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_cell(row, col);
      @(negedge clock);
      start = 1'b0;
   endtask

   task send_random_cells(int count);
      int nu, nv;
      for (int i = 0; i < count; i++) begin
         nu = int'(sb.steps_of(sb.regs[CSR_ANGLE_STEPS]));
         nv = int'(sb.steps_of(sb.regs[CSR_RING_STEPS]));
         if ($urandom_range(99) < 80)
            send_cell(8'($urandom_range(nv - 1)), 8'($urandom_range(nu - 1)));
         else
            send_cell(8'($urandom), 8'($urandom));
         if (i == count / 2 && $urandom_range(1)) wait_drained();
      end
   endtask

   task random_settings();
      wait_drained();
      for (int idx = 0; idx < 8; idx++) begin
         case ($urandom_range(3))
            0: write_reg(idx, 16'h0000);
            1: write_reg(idx, 16'hffff);
            2: write_reg(idx, 16'($urandom_range(1, 40)));
            default: write_reg(idx, 16'($urandom));
         endcase
      end
      // keep steps mostly small and meaningful
      if ($urandom_range(1)) write_reg(CSR_ANGLE_STEPS, 16'($urandom_range(1, 64)));
      if ($urandom_range(1)) write_reg(CSR_RING_STEPS, 16'($urandom_range(1, 16)));
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_cell_row = '0;
      req_cell_col = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_pct = 20;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults, corner and clamped cells
      send_cell(8'd0, 8'd0);
      send_cell(8'd0, 8'd31);
      send_cell(8'd255, 8'd255);
      send_cell(8'd0, 8'd16);
      wait_drained();
      write_reg(CSR_RING_STEPS, 16'd0);
      write_reg(CSR_ANGLE_STEPS, 16'h01ff);
      write_reg(7, 16'h1234);
      send_cell(8'd3, 8'd255);
      send_cell(8'd0, 8'd128);
      wait_drained();
      write_reg(CSR_RING_STEPS, 16'd256);
      write_reg(CSR_ANGLE_STEPS, 16'd256);
      write_reg(CSR_RING_START, 16'h7fff);
      write_reg(CSR_RING_END, 16'h8000);
      write_reg(CSR_RADIUS_SCALE, 16'hffff);
      write_reg(CSR_ANGLE_START, 16'h8000);
      write_reg(CSR_ANGLE_END, 16'h7fff);
      send_cell(8'd0, 8'd0);
      send_cell(8'd255, 8'd255);
      send_cell(8'd128, 8'd64);
      send_cell(8'd170, 8'd85);
      wait_drained();
      write_reg(CSR_RING_START, 16'h7fff);
      write_reg(CSR_RING_END, 16'h7fff);
      write_reg(CSR_RADIUS_SCALE, 16'h0000);
      send_cell(8'd10, 8'd10);
      wait_drained();
      write_reg(CSR_RADIUS_SCALE, 16'hffff);
      send_cell(8'd85, 8'd170);

      for (int phase = 0; phase < 6; phase++) begin
         idle_pct = (phase < 2) ? 20 : (phase < 4) ? 71 : 0;
         random_settings();
         send_random_cells(57);
      end

      wait_drained();
      if (sb.error_count == 0)
         $display("PASS disk_grid_tessellator_top");
      else
         $display("FAIL disk_grid_tessellator_top");
      $finish;
   end

endmodule

// ----- disk_grid_tessellator_top.f -----
rtl/dgt_pkg.sv
rtl/dgt_div.sv
rtl/disk_grid_tessellator_top.sv
verif/tb_top.sv
